@@ hw/rtl/qcpg_pkg.sv @@
// ----------------------------------------------------------------------------
// qcpg_pkg
// Shared types, widths and helper functions for the corner pair gap pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package qcpg_pkg;

   localparam int NUM_CORNERS = 4;
   localparam int CORNER_W    = 32;
   localparam int COORD_BITS  = 16;
   localparam int DIST_W      = 2 * COORD_BITS + 2;   // sum of two squared 17-bit diffs
   localparam int ROOT_W      = DIST_W / 2 + 1;       // one root bit per digit pair
   localparam int RAD_W       = 2 * ROOT_W;           // radicand padded to even width
   localparam int REM_W       = ROOT_W + 2;
   localparam int SQRT_STEPS  = 3;                    // root bits per stage
   localparam int SQRT_STAGES = ROOT_W / SQRT_STEPS;
   localparam int MEAN_W      = 17;
   localparam int NUM_PAIRS   = NUM_CORNERS * NUM_CORNERS;

   typedef logic [CORNER_W-1:0] corner_type;
   typedef logic [DIST_W-1:0]   dist_type;
   typedef logic [1:0]          idx_type;

   // squared distances plus the raw corners
   typedef struct packed {
      dist_type [NUM_PAIRS-1:0]     d;     // index {i, j}
      corner_type [NUM_CORNERS-1:0] a;
      corner_type [NUM_CORNERS-1:0] b;
   } dist_set_type;

   // per-row minimum, first column wins ties
   typedef struct packed {
      dist_type [NUM_CORNERS-1:0] row_min;
      idx_type [NUM_CORNERS-1:0]  row_j;
      dist_set_type               set;
   } row_set_type;

   // start rotations and reordered corners
   typedef struct packed {
      idx_type                      first_start;
      idx_type                      second_start;
      corner_type [NUM_CORNERS-1:0] first_ord;
      corner_type [NUM_CORNERS-1:0] second_ord;
   } meta_type;

   typedef struct packed {
      dist_type best;
      dist_type second;
      meta_type meta;
   } pick_type;

   // digit-by-digit square root state
   typedef struct packed {
      logic [RAD_W-1:0]  rad;
      logic [REM_W-1:0]  rem;
      logic [ROOT_W-1:0] root;
   } sqrt_type;

   typedef struct packed {
      sqrt_type lane_a;
      sqrt_type lane_b;
      meta_type meta;
   } root_set_type;

   // squared Euclidean distance of two packed points, x upper half, y lower
   function automatic dist_type sq_dist(input corner_type p, input corner_type q);
      logic signed [COORD_BITS:0]   dx;
      logic signed [COORD_BITS:0]   dy;
      logic signed [DIST_W-1:0]     sx;
      logic signed [DIST_W-1:0]     sy;
      dx = $signed({q[CORNER_W-1], q[CORNER_W-1:COORD_BITS]})
         - $signed({p[CORNER_W-1], p[CORNER_W-1:COORD_BITS]});
      dy = $signed({q[COORD_BITS-1], q[COORD_BITS-1:0]})
         - $signed({p[COORD_BITS-1], p[COORD_BITS-1:0]});
      sx = DIST_W'(dx) * DIST_W'(dx);
      sy = DIST_W'(dy) * DIST_W'(dy);
      return dist_type'(sx) + dist_type'(sy);
   endfunction

   // one root digit: bring down two radicand bits, try subtract
   function automatic sqrt_type sqrt_step(input sqrt_type s);
      logic [REM_W+1:0] rem2;
      logic [REM_W+1:0] trial;
      sqrt_type         n;
      rem2  = {s.rem, s.rad[RAD_W-1 -: 2]};
      trial = {2'b00, s.root, 2'b01};
      n.rad = {s.rad[RAD_W-3:0], 2'b00};
      if (rem2 >= trial) begin
         n.rem  = REM_W'(rem2 - trial);
         n.root = {s.root[ROOT_W-2:0], 1'b1};
      end else begin
         n.rem  = REM_W'(rem2);
         n.root = {s.root[ROOT_W-2:0], 1'b0};
      end
      return n;
   endfunction

endpackage

`default_nettype wire

@@ hw/rtl/qcpg_dist.sv @@
// ----------------------------------------------------------------------------
// qcpg_dist
// First stage: all sixteen squared corner distances, registered.
// ----------------------------------------------------------------------------
`default_nettype none

module qcpg_dist import qcpg_pkg::*; (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          in_valid,
   output      logic                          in_ready,
   input  wire corner_type [NUM_CORNERS-1:0]  in_a,
   input  wire corner_type [NUM_CORNERS-1:0]  in_b,
   output      logic                          out_valid,
   input  wire logic                          out_ready,
   output      dist_set_type                  out_set
);

   logic         valid_ff;
   dist_set_type set_ff;
   dist_set_type set_in;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_set   = set_ff;

   // distance matrix, row = first quad corner
   always_comb begin
      set_in.a = in_a;
      set_in.b = in_b;
      for (int i = 0; i < NUM_CORNERS; i++) begin
         for (int j = 0; j < NUM_CORNERS; j++) begin
            set_in.d[i*NUM_CORNERS+j] = sq_dist(in_a[i], in_b[j]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         set_ff <= set_in;
      end
   end

endmodule

`default_nettype wire

@@ hw/rtl/qcpg_select.sv @@
// ----------------------------------------------------------------------------
// qcpg_select
// Two stages: row minima, then global minimum, neighbor choice and reorder.
// ----------------------------------------------------------------------------
`default_nettype none

module qcpg_select import qcpg_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          in_valid,
   output      logic          in_ready,
   input  wire dist_set_type  in_set,
   output      logic          out_valid,
   input  wire logic          out_ready,
   output      pick_type      out_pick
);

   logic        row_valid_ff;
   row_set_type row_ff;
   row_set_type row_in;
   logic        row_ready;
   logic        pick_valid_ff;
   pick_type    pick_ff;
   pick_type    pick_in;

   assign row_ready = !pick_valid_ff || out_ready;
   assign in_ready  = !row_valid_ff || row_ready;
   assign out_valid = pick_valid_ff;
   assign out_pick  = pick_ff;

   // per-row minimum, strict less keeps the first column
   always_comb begin
      row_in.set = in_set;
      for (int i = 0; i < NUM_CORNERS; i++) begin
         row_in.row_min[i] = in_set.d[i*NUM_CORNERS];
         row_in.row_j[i]   = '0;
         for (int j = 1; j < NUM_CORNERS; j++) begin
            if (in_set.d[i*NUM_CORNERS+j] < row_in.row_min[i]) begin
               row_in.row_min[i] = in_set.d[i*NUM_CORNERS+j];
               row_in.row_j[i]   = idx_type'(j);
            end
         end
      end
   end

   // global minimum, diagonal neighbors, start rotations
   always_comb begin
      dist_type best;
      idx_type  bi;
      idx_type  bj;
      dist_type n0;
      dist_type n1;
      idx_type  fi;
      idx_type  sj;
      best = row_ff.row_min[0];
      bi   = '0;
      for (int i = 1; i < NUM_CORNERS; i++) begin
         if (row_ff.row_min[i] < best) begin
            best = row_ff.row_min[i];
            bi   = idx_type'(i);
         end
      end
      bj = row_ff.row_j[bi];
      n0 = row_ff.set.d[{idx_type'(bi - 2'd1), idx_type'(bj + 2'd1)}];
      n1 = row_ff.set.d[{idx_type'(bi + 2'd1), idx_type'(bj - 2'd1)}];
      // neighbor tie takes the second one
      if (n0 < n1) begin
         pick_in.second = n0;
         fi             = bi;
         sj             = bj;
      end else begin
         pick_in.second = n1;
         fi             = bi + 2'd1;
         sj             = bj - 2'd1;
      end
      pick_in.best              = best;
      pick_in.meta.first_start  = fi;
      pick_in.meta.second_start = sj + 2'd1;
      for (int k = 0; k < NUM_CORNERS; k++) begin
         pick_in.meta.first_ord[k]  = row_ff.set.a[idx_type'(fi + idx_type'(k))];
         pick_in.meta.second_ord[k] = row_ff.set.b[idx_type'(sj + 2'd1 + idx_type'(k))];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff  <= 1'b0;
         pick_valid_ff <= 1'b0;
      end else begin
         if (in_ready) begin
            row_valid_ff <= in_valid;
         end
         if (row_ready) begin
            pick_valid_ff <= row_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         row_ff <= row_in;
      end
      if (row_ready && row_valid_ff) begin
         pick_ff <= pick_in;
      end
   end

   // the closest pair can never be farther than its chosen neighbor
   a_best_le_second: assert property (@(posedge clock) disable iff (reset)
      pick_valid_ff |-> (pick_ff.best <= pick_ff.second))
      else $error("closest pair exceeds neighbor distance");

endmodule

`default_nettype wire

@@ hw/rtl/qcpg_sqrt.sv @@
// ----------------------------------------------------------------------------
// qcpg_sqrt
// Pipelined integer square root of both chosen distances, several digits
// per stage; the corner metadata rides along.
// ----------------------------------------------------------------------------
`default_nettype none

module qcpg_sqrt import qcpg_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          in_valid,
   output      logic          in_ready,
   input  wire pick_type      in_pick,
   output      logic          out_valid,
   input  wire logic          out_ready,
   output      root_set_type  out_roots
);

   logic [SQRT_STAGES-1:0] valid_ff;
   logic [SQRT_STAGES-1:0] ready;
   root_set_type           stage_ff [SQRT_STAGES];
   root_set_type           stage_in [SQRT_STAGES];
   root_set_type           seed;

   // radicand loaded at the top, zero remainder and root
   always_comb begin
      seed.lane_a.rad  = RAD_W'(in_pick.best);
      seed.lane_a.rem  = '0;
      seed.lane_a.root = '0;
      seed.lane_b.rad  = RAD_W'(in_pick.second);
      seed.lane_b.rem  = '0;
      seed.lane_b.root = '0;
      seed.meta        = in_pick.meta;
   end

   for (genvar s = 0; s < SQRT_STAGES; s++) begin : g_stage
      root_set_type src;
      logic         src_valid;

      if (s == 0) begin : g_first
         assign src       = seed;
         assign src_valid = in_valid;
      end else begin : g_next
         assign src       = stage_ff[s-1];
         assign src_valid = valid_ff[s-1];
      end

      if (s == SQRT_STAGES - 1) begin : g_last
         assign ready[s] = !valid_ff[s] || out_ready;
      end else begin : g_mid
         assign ready[s] = !valid_ff[s] || ready[s+1];
      end

      // a few root digits per stage for both lanes
      always_comb begin
         stage_in[s] = src;
         for (int k = 0; k < SQRT_STEPS; k++) begin
            stage_in[s].lane_a = sqrt_step(stage_in[s].lane_a);
            stage_in[s].lane_b = sqrt_step(stage_in[s].lane_b);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (ready[s]) begin
            valid_ff[s] <= src_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (ready[s] && src_valid) begin
            stage_ff[s] <= stage_in[s];
         end
      end
   end

   assign in_ready  = ready[0];
   assign out_valid = valid_ff[SQRT_STAGES-1];
   assign out_roots = stage_ff[SQRT_STAGES-1];

   // a finished root leaves a remainder of at most twice the root
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      out_valid |-> ((REM_W+1)'(out_roots.lane_a.rem) <= {out_roots.lane_a.root, 1'b0}) &&
                    ((REM_W+1)'(out_roots.lane_b.rem) <= {out_roots.lane_b.root, 1'b0}))
      else $error("square root remainder out of range");

endmodule

`default_nettype wire

@@ hw/rtl/quad_corner_pair_gap.sv @@
// ----------------------------------------------------------------------------
// quad_corner_pair_gap
// Closest corner pairing of two quadrilaterals with mean corner gap.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one transaction per pair of quadrilaterals: eight packed
//   corners, each {x, y} as signed Q12.4. rsp_* returns one transaction per
//   request: the mean of the two chosen corner distances (Q13.4, truncated),
//   the two start rotations and both corner sets in rotated order.
//   From request acceptance to rsp_tvalid a transaction passes one stage of
//   distance multipliers, two selection stages, six square root stages (three
//   root digits each, for both distances in parallel) and the output register.
//   Throughput is one transaction per cycle while rsp_tready is high; every
//   stage has its own valid bit and its own ready, so bubbles close up and a
//   new request is taken while a finished response waits.
//   Reset clears all valid bits; no response is pending afterwards.
//   When rsp_tready is low the response holds and the stages behind it fill;
//   req_tready drops only once every stage holds a transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module quad_corner_pair_gap import qcpg_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output      logic         req_tready,
   // first_corner_0..3, second_corner_0..3, 32 bits each
   input  wire logic [255:0] req_tdata,
   output      logic         rsp_tvalid,
   input  wire logic         rsp_tready,
   // mean_gap[16:0], first_start[18:17], second_start[20:19],
   // first_ordered_0..3 [148:21], second_ordered_0..3 [276:149], zero pad
   output      logic [279:0] rsp_tdata
);

   corner_type [NUM_CORNERS-1:0] req_a;
   corner_type [NUM_CORNERS-1:0] req_b;
   logic                         dist_valid;
   logic                         dist_ready;
   dist_set_type                 dist_set;
   logic                         pick_valid;
   logic                         pick_ready;
   pick_type                     pick;
   logic                         root_valid;
   logic                         root_ready;
   root_set_type                 roots;
   logic                         rsp_valid_ff;
   logic [279:0]                 rsp_data_ff;
   logic [279:0]                 rsp_data_in;
   logic [ROOT_W:0]              root_sum;

   assign req_a = req_tdata[127:0];
   assign req_b = req_tdata[255:128];

   qcpg_dist u_dist (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_a      (req_a),
      .in_b      (req_b),
      .out_valid (dist_valid),
      .out_ready (dist_ready),
      .out_set   (dist_set)
   );

   qcpg_select u_select (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (dist_valid),
      .in_ready  (dist_ready),
      .in_set    (dist_set),
      .out_valid (pick_valid),
      .out_ready (pick_ready),
      .out_pick  (pick)
   );

   qcpg_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (pick_valid),
      .in_ready  (pick_ready),
      .in_pick   (pick),
      .out_valid (root_valid),
      .out_ready (root_ready),
      .out_roots (roots)
   );

   // mean of both roots and response packing
   always_comb begin
      root_sum    = {1'b0, roots.lane_a.root} + {1'b0, roots.lane_b.root};
      rsp_data_in = '0;
      rsp_data_in[16:0]    = root_sum[MEAN_W:1];
      rsp_data_in[18:17]   = roots.meta.first_start;
      rsp_data_in[20:19]   = roots.meta.second_start;
      rsp_data_in[148:21]  = roots.meta.first_ord;
      rsp_data_in[276:149] = roots.meta.second_ord;
   end

   assign root_ready = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (root_ready) begin
         rsp_valid_ff <= root_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (root_ready && root_valid) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // an empty output register lets the whole pipeline move
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff |-> req_tready)
      else $error("request stalled with empty response register");

   // the pad bits stay zero
   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff[279:277] == 3'b000))
      else $error("response pad bits set");

endmodule

`default_nettype wire

@@ sim/qcpg_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qcpg_checker
// Watches both channels of quad_corner_pair_gap, predicts each response from
// the accepted request and compares it field by field in arrival order.
// ----------------------------------------------------------------------------
`default_nettype none

module qcpg_checker (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   input  wire logic         req_tready,
   input  wire logic [255:0] req_tdata,
   input  wire logic         rsp_tvalid,
   input  wire logic         rsp_tready,
   input  wire logic [279:0] rsp_tdata,
   output int                fail_count,
   output int                pending
);

   logic [279:0] gap_queue[$];

   // signed 16-bit coordinate difference, squared and summed
   function automatic longint unsigned corner_dist(input logic [31:0] p, input logic [31:0] q);
      longint dx;
      longint dy;
      dx = longint'($signed(q[31:16])) - longint'($signed(p[31:16]));
      dy = longint'($signed(q[15:0])) - longint'($signed(p[15:0]));
      return longint'(dx * dx + dy * dy);
   endfunction

   // integer square root by bisection
   function automatic longint unsigned root_floor(input longint unsigned n);
      longint unsigned lo;
      longint unsigned hi;
      longint unsigned mid;
      lo = 0;
      hi = 64'd4294967296;
      while (hi - lo > 1) begin
         mid = (lo + hi) >> 1;
         if (mid * mid <= n) lo = mid;
         else hi = mid;
      end
      return lo;
   endfunction

   function automatic logic [279:0] predict_gap(input logic [255:0] quads);
      logic [31:0]     a[4];
      logic [31:0]     b[4];
      longint unsigned d[4][4];
      longint unsigned best;
      longint unsigned near;
      longint unsigned s0;
      longint unsigned s1;
      logic [1:0]      bi;
      logic [1:0]      bj;
      logic [16:0]     mean;
      logic [279:0]    r;
      for (int k = 0; k < 4; k++) begin
         a[k] = quads[32*k +: 32];
         b[k] = quads[128 + 32*k +: 32];
      end
      for (int i = 0; i < 4; i++)
         for (int j = 0; j < 4; j++)
            d[i][j] = corner_dist(a[i], b[j]);
      best = d[0][0];
      bi = 0;
      bj = 0;
      for (int i = 0; i < 4; i++)
         for (int j = 0; j < 4; j++)
            if (d[i][j] < best) begin
               best = d[i][j];
               bi = 2'(i);
               bj = 2'(j);
            end
      s0 = d[bi - 2'd1][bj + 2'd1];
      s1 = d[bi + 2'd1][bj - 2'd1];
      // tie between neighbors takes the second one
      if (s0 < s1) begin
         near = s0;
      end else begin
         near = s1;
         bi = bi + 2'd1;
         bj = bj - 2'd1;
      end
      bj = bj + 2'd1;
      mean = 17'((root_floor(best) + root_floor(near)) >> 1);
      r = '0;
      r[16:0] = mean;
      r[18:17] = bi;
      r[20:19] = bj;
      for (int k = 0; k < 4; k++) begin
         r[21 + 32*k +: 32] = a[bi + 2'(k)];
         r[149 + 32*k +: 32] = b[bj + 2'(k)];
      end
      return r;
   endfunction

   // predict on request transactions, compare on response transactions
   always @(posedge clock) begin
      logic [279:0] want;
      if (reset) begin
         fail_count <= 0;
         pending <= 0;
      end else begin
         if (req_tvalid && req_tready) gap_queue.push_back(predict_gap(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            if (gap_queue.size() == 0) begin
               $display("%0t: unexpected response expected none actual %h", $time, rsp_tdata);
               fail_count <= fail_count + 1;
            end else begin
               want = gap_queue.pop_front();
               if (want[16:0] !== rsp_tdata[16:0] || want[18:17] !== rsp_tdata[18:17]
                   || want[20:19] !== rsp_tdata[20:19]
                   || want[148:21] !== rsp_tdata[148:21]
                   || want[279:149] !== rsp_tdata[279:149]) begin
                  $display("%0t: mismatch expected %h actual %h", $time, want, rsp_tdata);
                  fail_count <= fail_count + 1;
               end
            end
         end
         pending <= gap_queue.size();
      end
   end

endmodule

`default_nettype wire

@@ sim/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for quad_corner_pair_gap: directed corner sets, then random quads,
// most built around a shared center, with random idling and one long
// back-pressure stretch; qcpg_checker does the comparing.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
   import qcpg_pkg::*;

   logic         clock = 0;
   logic         reset = 1;
   logic         req_tvalid = 0;
   logic         req_tready;
   logic [255:0] req_tdata = '0;   // first_corner_0..3, second_corner_0..3
   logic         rsp_tvalid;
   logic         rsp_tready = 0;
   logic [279:0] rsp_tdata;        // mean_gap, first_start, second_start, ordered corners
   int           fail_count;
   int           pending;
   int           cycle_count = 0;
   bit           hold_off = 0;
   bit           calm = 0;

   always #4 clock = ~clock;

   quad_corner_pair_gap dut (.*);

   qcpg_checker checker_inst (.*);

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 200000) begin
         $display("status: fail");
         $finish;
      end
   end

   // receiver: random stalls, plus one long hold-off
   always @(posedge clock) begin
      if (reset) rsp_tready <= 0;
      else rsp_tready <= !hold_off && (calm || $urandom_range(99) >= 7);
   end

   function automatic logic [31:0] near_corner(input logic [31:0] c, input int spread);
      logic [15:0] x;
      logic [15:0] y;
      x = c[31:16] + 16'($urandom_range(2*spread) - spread);
      y = c[15:0] + 16'($urandom_range(2*spread) - spread);
      return {x, y};
   endfunction

   task automatic send_quads(input logic [255:0] quads);
      req_tdata <= quads;
      req_tvalid <= 1;
      do @(posedge clock); while (!req_tready);
      if (!calm && $urandom_range(99) < 7) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
   endtask

   task automatic send_random;
      logic [255:0] q;
      logic [31:0]  c;
      int           spread;
      int           mode;
      mode = $urandom_range(9);
      c = $urandom;
      spread = (mode < 5) ? $urandom_range(8) : $urandom_range(3000);
      for (int k = 0; k < 8; k++)
         q[32*k +: 32] = (mode == 9) ? $urandom : near_corner(c, spread);
      send_quads(q);
   endtask

   initial begin
      logic [255:0] q;
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // extremes and coincident corners
      send_quads('0);
      send_quads('1);
      send_quads({8{32'h7fff_7fff}});
      send_quads({{4{32'h8000_8000}}, {4{32'h7fff_7fff}}});
      send_quads({{4{32'h7fff_8000}}, {4{32'h8000_7fff}}});
      send_quads({32'h8000_8000, 32'h7fff_8000, 32'h7fff_7fff, 32'h8000_7fff,
                  32'h7fff_7fff, 32'h8000_7fff, 32'h8000_8000, 32'h7fff_8000});
      // equal distances: coincident and offset squares so many pairs tie
      send_quads({32'h0000_0010, 32'h0010_0010, 32'h0010_0000, 32'h0000_0000,
                  32'h0000_0010, 32'h0010_0010, 32'h0010_0000, 32'h0000_0000});
      send_quads({32'h0000_0020, 32'h0020_0020, 32'h0020_0000, 32'h0000_0000,
                  32'h0010_0030, 32'h0030_0030, 32'h0030_0010, 32'h0010_0010});
      // every closest pair position
      for (int i = 0; i < 4; i++)
         for (int j = 0; j < 4; j++) begin
            q = '0;
            for (int k = 0; k < 8; k++) q[32*k +: 32] = {16'(k * 300), 16'(k * 170)};
            q[128 + 32*j +: 32] = q[32*i +: 32] + 32'h0001_0001;
            send_quads(q);
         end
      // long back-pressure stretch
      hold_off = 1;
      fork
         begin
            repeat (40) send_random();
         end
         begin
            repeat (60) @(posedge clock);
            hold_off = 0;
         end
      join
      repeat (300) send_random();
      calm = 1;
      repeat (150) send_random();
      calm = 0;
      repeat (160) send_random();
      req_tvalid <= 0;
      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

`default_nettype wire
